FILE: rtl/core/camera_motion_blur_estimator_unit_assert.svh
// Assertion macros used by the checker file.
// No dependencies.
`ifndef CAMERA_MOTION_BLUR_ESTIMATOR_UNIT_ASSERT_SVH
`define CAMERA_MOTION_BLUR_ESTIMATOR_UNIT_ASSERT_SVH

// same-cycle implication
`define CMBE_ASSERT_IMPLY(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error("assertion failed: same-cycle implication");

// next-cycle implication
`define CMBE_ASSERT_NEXT(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error("assertion failed: next-cycle implication");

`endif

FILE: rtl/core/cmbe_pkg.sv
// Package for the camera motion blur estimator: constants, unit ops, request struct.
// No dependencies.
package cmbe_pkg;

    localparam int TIME_WIDTH = 32;
    localparam int DT_MAX_MS  = 80;
    localparam int DT_W       = $clog2(DT_MAX_MS + 1);

    localparam int UNIT_AW = 56;
    localparam int UNIT_BW = 32;
    localparam int REM_W   = 34;
    localparam int CNT_W   = 6;

    localparam int MUL_STEPS  = 32;
    localparam int DIV_STEPS  = 56;
    localparam int SQRT_STEPS = 28;

    localparam int VEL_W = 40;

    localparam logic [2:0] REG_STAGE_MAX_DIM = 3'd0;
    localparam logic [2:0] REG_BLUR_AMOUNT   = 3'd1;
    localparam logic [2:0] REG_AMOUNT_BOOST  = 3'd2;
    localparam logic [2:0] REG_PEAK_VELOCITY = 3'd3;
    localparam logic [2:0] REG_VEL_THRESHOLD = 3'd4;
    localparam logic [2:0] REG_MAX_BLUR      = 3'd5;

    typedef enum logic [1:0] {
        OP_MUL,
        OP_DIV,
        OP_SQRT
    } unit_op_t;

    typedef struct packed {
        logic                 start;
        unit_op_t             op;
        logic [UNIT_AW-1:0]   a;
        logic [UNIT_BW-1:0]   b;
    } unit_req_t;

endpackage

FILE: rtl/core/cmbe_ifs.sv
// Channel interfaces: frame input, result output, configuration writes.
// Depends on nothing.
interface cmbe_in_if;
    logic               valid;
    logic               ready;
    logic signed [23:0] cam_x;
    logic signed [23:0] cam_y;
    logic [23:0]        cam_scale;
    logic [31:0]        frame_time_ms;
    modport source (output valid, cam_x, cam_y, cam_scale, frame_time_ms, input ready);
    modport sink (input valid, cam_x, cam_y, cam_scale, frame_time_ms, output ready);
endinterface

interface cmbe_out_if;
    logic               valid;
    logic               ready;
    logic signed [39:0] velocity_x;
    logic signed [39:0] velocity_y;
    logic [15:0]        blur_px;
    logic               primed;
    modport source (output valid, velocity_x, velocity_y, blur_px, primed, input ready);
    modport sink (input valid, velocity_x, velocity_y, blur_px, primed, output ready);
endinterface

interface cmbe_cfg_if;
    logic        valid;
    logic        ready;
    logic [2:0]  index;
    logic [31:0] data;
    modport source (output valid, index, data, input ready);
    modport sink (input valid, index, data, output ready);
endinterface

FILE: rtl/core/cmbe_serial_unit.sv
// Shared bit-serial unit: shift-add multiply, restoring divide, digit square root.
// Depends on cmbe_pkg.
module cmbe_serial_unit
    import cmbe_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  unit_req_t          req,
    output logic               done,
    output logic [UNIT_AW-1:0] result
);

    logic               busy_reg;
    unit_op_t           op_reg;
    logic [CNT_W-1:0]   cnt_reg;
    logic [UNIT_AW-1:0] acc_reg;
    logic [UNIT_AW-1:0] a_reg;
    logic [UNIT_BW-1:0] b_reg;
    logic [REM_W-1:0]   rem_reg;
    logic               done_reg;

    logic [REM_W-1:0]   div_sh;
    logic [REM_W-1:0]   sq_sh;
    logic [REM_W-1:0]   sq_trial;
    logic               div_ge;
    logic               sq_ge;
    logic [CNT_W-1:0]   last_cnt;

    assign div_sh   = {rem_reg[REM_W-2:0], a_reg[UNIT_AW-1]};
    assign div_ge   = div_sh >= {{(REM_W-UNIT_BW){1'b0}}, b_reg};
    assign sq_sh    = {rem_reg[REM_W-3:0], a_reg[UNIT_AW-1:UNIT_AW-2]};
    assign sq_trial = {{(REM_W-SQRT_STEPS-2){1'b0}}, acc_reg[SQRT_STEPS-1:0], 2'b01};
    assign sq_ge    = sq_sh >= sq_trial;

    always_comb
    begin
        case (op_reg)
            OP_MUL:  last_cnt = CNT_W'(MUL_STEPS - 1);
            OP_DIV:  last_cnt = CNT_W'(DIV_STEPS - 1);
            OP_SQRT: last_cnt = CNT_W'(SQRT_STEPS - 1);
            default: last_cnt = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            op_reg   <= OP_MUL;
            cnt_reg  <= '0;
            acc_reg  <= '0;
            a_reg    <= '0;
            b_reg    <= '0;
            rem_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (req.start)
            begin
                busy_reg <= 1'b1;
                op_reg   <= req.op;
                cnt_reg  <= '0;
                acc_reg  <= '0;
                a_reg    <= req.a;
                b_reg    <= req.b;
                rem_reg  <= '0;
            end
            else if (busy_reg)
            begin
                case (op_reg)
                    OP_MUL:
                    begin
                        if (b_reg[0])
                            acc_reg <= acc_reg + a_reg;
                        a_reg <= {a_reg[UNIT_AW-2:0], 1'b0};
                        b_reg <= {1'b0, b_reg[UNIT_BW-1:1]};
                    end
                    OP_DIV:
                    begin
                        rem_reg <= div_ge ? div_sh - {{(REM_W-UNIT_BW){1'b0}}, b_reg} : div_sh;
                        acc_reg <= {acc_reg[UNIT_AW-2:0], div_ge};
                        a_reg   <= {a_reg[UNIT_AW-2:0], 1'b0};
                    end
                    OP_SQRT:
                    begin
                        rem_reg <= sq_ge ? sq_sh - sq_trial : sq_sh;
                        acc_reg <= {acc_reg[UNIT_AW-2:0], sq_ge};
                        a_reg   <= {a_reg[UNIT_AW-3:0], 2'b00};
                    end
                    default:
                    begin
                        acc_reg <= acc_reg;
                    end
                endcase
                cnt_reg <= cnt_reg + 1'b1;
                if (cnt_reg == last_cnt)
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    assign done   = done_reg;
    assign result = acc_reg;

endmodule

FILE: rtl/core/camera_motion_blur_estimator_unit.sv
// Camera motion blur estimator top level: frame state, sequencer, config registers.
// Depends on cmbe_pkg, cmbe_ifs, cmbe_serial_unit.
//
//  channel  | dir | transaction
//  ---------+-----+--------------------------------------------------
//  frame    | in  | cam_x, cam_y, cam_scale, frame_time_ms
//  result   | out | velocity_x, velocity_y, blur_px, primed
//  cfg      | in  | index, data (register write, always ready)
//
// Priming frame: goes from accept to S_OUT, which loads the result register once it is free.
// Other frames run serial-unit ops one at a time (multiply, divide, sqrt): frames below the
// threshold stop after the sqrt, zero peak velocity skips the divide by it, others run all ops.
// One frame in flight; the next frame is taken while the result waits in its register.
// Reset clears the stored frame state and loads the register defaults.
module camera_motion_blur_estimator_unit
    import cmbe_pkg::*;
(
    input logic         clk,
    input logic         rst_n,
    cmbe_in_if.sink     frame,
    cmbe_out_if.source  result,
    cmbe_cfg_if.sink    cfg
);

    typedef enum logic [4:0] {
        S_IDLE, S_MX_MUL, S_MX_DIV, S_MY_MUL, S_MY_DIV,
        S_S_MUL1, S_S_MUL2, S_S_DIV, S_SQ_X, S_SQ_Y, S_SQRT,
        S_N_DIV, S_N2, S_F, S_R, S_P1, S_P2, S_OUT
    } state_t;

    state_t state_reg;

    logic [13:0] smd_reg;
    logic [16:0] ba_reg;
    logic [12:0] boost_reg;
    logic [15:0] pv_reg;
    logic [15:0] thr_reg;
    logic [13:0] mb_reg;

    logic                  have_prev_reg;
    logic [TIME_WIDTH-1:0] last_time_reg;
    logic [23:0]           prev_x_reg;
    logic [23:0]           prev_y_reg;
    logic [23:0]           prev_s_reg;

    logic [DT_W-1:0] dt_reg;
    logic [24:0]     mag_y_reg;
    logic [24:0]     mag_s_reg;
    logic            neg_x_reg;
    logic            neg_y_reg;
    logic [34:0]     mx_reg;
    logic [34:0]     my_reg;
    logic [25:0]     sv_reg;
    logic [51:0]     sum_reg;
    logic [16:0]     n2_reg;
    logic [22:0]     r_reg;
    logic [VEL_W-1:0] vx_reg;
    logic [VEL_W-1:0] vy_reg;
    logic [15:0]     blur_reg;
    logic            primed_reg;

    logic             ov_reg;
    logic [VEL_W-1:0] vx_out_reg;
    logic [VEL_W-1:0] vy_out_reg;
    logic [15:0]      blur_out_reg;
    logic             primed_out_reg;

    unit_req_t          req_reg;
    logic               u_done;
    logic [UNIT_AW-1:0] u_res;

    logic                  accept;
    logic [TIME_WIDTH-1:0] d_c;
    logic [DT_W-1:0]       dt_c;
    logic signed [24:0]    dx_c;
    logic signed [24:0]    dy_c;
    logic signed [24:0]    ds_c;
    logic [25:0]           cmx_c;
    logic [25:0]           cmy_c;
    logic [25:0]           csv_c;
    logic [27:0]           speed_c;
    logic [16:0]           n_c;
    logic [16:0]           a_c;
    logic                  boost_ge;
    logic [12:0]           bdiff_c;
    logic [21:0]           f_c;
    logic [23:0]           p_c;
    logic [VEL_W-1:0]      vmag_c;

    assign accept = frame.valid && frame.ready;
    assign frame.ready = (state_reg == S_IDLE);
    assign cfg.ready = 1'b1;

    assign d_c  = frame.frame_time_ms[TIME_WIDTH-1:0] - last_time_reg;
    always_comb
    begin
        if (d_c == '0 || d_c[TIME_WIDTH-1])
            dt_c = DT_W'(1);
        else if (d_c > TIME_WIDTH'(DT_MAX_MS))
            dt_c = DT_W'(DT_MAX_MS);
        else
            dt_c = d_c[DT_W-1:0];
    end

    assign dx_c = 25'(frame.cam_x) - 25'(signed'(prev_x_reg));
    assign dy_c = 25'(frame.cam_y) - 25'(signed'(prev_y_reg));
    assign ds_c = signed'({1'b0, frame.cam_scale}) - signed'({1'b0, prev_s_reg});

    assign cmx_c = (mx_reg > 35'(1 << 25)) ? 26'(1 << 25) : mx_reg[25:0];
    assign cmy_c = (my_reg > 35'(1 << 25)) ? 26'(1 << 25) : my_reg[25:0];
    assign csv_c = (u_res > UNIT_AW'(1 << 25)) ? 26'(1 << 25) : u_res[25:0];
    assign speed_c = 28'(u_res[SQRT_STEPS-1:0]) + 28'(sv_reg);
    assign n_c = (u_res > UNIT_AW'(65536)) ? 17'h10000 : u_res[16:0];
    assign a_c = (ba_reg > 17'h10000) ? 17'h10000 : ba_reg;
    assign boost_ge = boost_reg >= 13'd256;
    assign bdiff_c = boost_ge ? boost_reg - 13'd256 : 13'd256 - boost_reg;
    assign f_c = boost_ge ? 22'h10000 + 22'(u_res[UNIT_AW-1:8])
                          : 22'h10000 - 22'(u_res[UNIT_AW-1:8]);
    assign p_c = u_res[55:32];
    assign vmag_c = u_res[VEL_W-1:0];

    cmbe_serial_unit u_unit (
        .clk    (clk),
        .rst_n  (rst_n),
        .req    (req_reg),
        .done   (u_done),
        .result (u_res)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            smd_reg   <= 14'd1920;
            ba_reg    <= 17'd32768;
            boost_reg <= 13'd512;
            pv_reg    <= 16'd2000;
            thr_reg   <= 16'd20;
            mb_reg    <= 14'd2048;
        end
        else if (cfg.valid)
        begin
            case (cfg.index)
                REG_STAGE_MAX_DIM: smd_reg   <= cfg.data[13:0];
                REG_BLUR_AMOUNT:   ba_reg    <= cfg.data[16:0];
                REG_AMOUNT_BOOST:  boost_reg <= cfg.data[12:0];
                REG_PEAK_VELOCITY: pv_reg    <= cfg.data[15:0];
                REG_VEL_THRESHOLD: thr_reg   <= cfg.data[15:0];
                REG_MAX_BLUR:      mb_reg    <= cfg.data[13:0];
                default:           smd_reg   <= smd_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            have_prev_reg  <= 1'b0;
            last_time_reg  <= '0;
            prev_x_reg     <= '0;
            prev_y_reg     <= '0;
            prev_s_reg     <= '0;
            req_reg        <= '0;
            ov_reg         <= 1'b0;
            dt_reg         <= '0;
            mag_y_reg      <= '0;
            mag_s_reg      <= '0;
            neg_x_reg      <= 1'b0;
            neg_y_reg      <= 1'b0;
            mx_reg         <= '0;
            my_reg         <= '0;
            sv_reg         <= '0;
            sum_reg        <= '0;
            n2_reg         <= '0;
            r_reg          <= '0;
            vx_reg         <= '0;
            vy_reg         <= '0;
            blur_reg       <= '0;
            primed_reg     <= 1'b0;
            vx_out_reg     <= '0;
            vy_out_reg     <= '0;
            blur_out_reg   <= '0;
            primed_out_reg <= 1'b0;
        end
        else
        begin
            // start is a one-cycle pulse; the unit never finishes in the cycle after it
            if (req_reg.start)
                req_reg.start <= 1'b0;
            if (ov_reg && result.ready && state_reg != S_OUT)
                ov_reg <= 1'b0;

            case (state_reg)
                S_IDLE:
                begin
                    if (accept)
                    begin
                        have_prev_reg <= 1'b1;
                        last_time_reg <= frame.frame_time_ms[TIME_WIDTH-1:0];
                        prev_x_reg    <= frame.cam_x;
                        prev_y_reg    <= frame.cam_y;
                        prev_s_reg    <= frame.cam_scale;
                        dt_reg        <= dt_c;
                        mag_y_reg     <= dy_c[24] ? 25'(-dy_c) : dy_c;
                        mag_s_reg     <= ds_c[24] ? 25'(-ds_c) : ds_c;
                        neg_x_reg     <= dx_c[24];
                        neg_y_reg     <= dy_c[24];
                        blur_reg      <= '0;
                        if (!have_prev_reg)
                        begin
                            vx_reg     <= '0;
                            vy_reg     <= '0;
                            primed_reg <= 1'b1;
                            state_reg  <= S_OUT;
                        end
                        else
                        begin
                            primed_reg <= 1'b0;
                            req_reg    <= '{1'b1, OP_MUL,
                                           UNIT_AW'(dx_c[24] ? 25'(-dx_c) : dx_c),
                                           UNIT_BW'(1000)};
                            state_reg  <= S_MX_MUL;
                        end
                    end
                end
                S_MX_MUL:
                begin
                    if (u_done)
                    begin
                        req_reg   <= '{1'b1, OP_DIV, u_res + UNIT_AW'(dt_reg >> 1),
                                      UNIT_BW'(dt_reg)};
                        state_reg <= S_MX_DIV;
                    end
                end
                S_MX_DIV:
                begin
                    if (u_done)
                    begin
                        mx_reg    <= u_res[34:0];
                        vx_reg    <= neg_x_reg ? VEL_W'(-vmag_c) : vmag_c;
                        req_reg   <= '{1'b1, OP_MUL, UNIT_AW'(mag_y_reg), UNIT_BW'(1000)};
                        state_reg <= S_MY_MUL;
                    end
                end
                S_MY_MUL:
                begin
                    if (u_done)
                    begin
                        req_reg   <= '{1'b1, OP_DIV, u_res + UNIT_AW'(dt_reg >> 1),
                                      UNIT_BW'(dt_reg)};
                        state_reg <= S_MY_DIV;
                    end
                end
                S_MY_DIV:
                begin
                    if (u_done)
                    begin
                        my_reg    <= u_res[34:0];
                        vy_reg    <= neg_y_reg ? VEL_W'(-vmag_c) : vmag_c;
                        req_reg   <= '{1'b1, OP_MUL, UNIT_AW'(mag_s_reg), UNIT_BW'(1000)};
                        state_reg <= S_S_MUL1;
                    end
                end
                S_S_MUL1:
                begin
                    if (u_done)
                    begin
                        req_reg   <= '{1'b1, OP_MUL, u_res, UNIT_BW'(smd_reg)};
                        state_reg <= S_S_MUL2;
                    end
                end
                S_S_MUL2:
                begin
                    if (u_done)
                    begin
                        req_reg   <= '{1'b1, OP_DIV, u_res >> 9, UNIT_BW'(dt_reg)};
                        state_reg <= S_S_DIV;
                    end
                end
                S_S_DIV:
                begin
                    if (u_done)
                    begin
                        sv_reg    <= csv_c;
                        req_reg   <= '{1'b1, OP_MUL, UNIT_AW'(cmx_c), UNIT_BW'(cmx_c)};
                        state_reg <= S_SQ_X;
                    end
                end
                S_SQ_X:
                begin
                    if (u_done)
                    begin
                        sum_reg   <= u_res[51:0];
                        req_reg   <= '{1'b1, OP_MUL, UNIT_AW'(cmy_c), UNIT_BW'(cmy_c)};
                        state_reg <= S_SQ_Y;
                    end
                end
                S_SQ_Y:
                begin
                    if (u_done)
                    begin
                        req_reg   <= '{1'b1, OP_SQRT, UNIT_AW'(sum_reg) + u_res, '0};
                        state_reg <= S_SQRT;
                    end
                end
                S_SQRT:
                begin
                    if (u_done)
                    begin
                        if (speed_c < {4'd0, thr_reg, 8'd0})
                            state_reg <= S_OUT;
                        else if (pv_reg == '0)
                        begin
                            req_reg   <= '{1'b1, OP_MUL, UNIT_AW'(17'h10000),
                                          UNIT_BW'(17'h10000)};
                            state_reg <= S_N2;
                        end
                        else
                        begin
                            req_reg   <= '{1'b1, OP_DIV, UNIT_AW'({speed_c, 8'd0}),
                                          UNIT_BW'(pv_reg)};
                            state_reg <= S_N_DIV;
                        end
                    end
                end
                S_N_DIV:
                begin
                    if (u_done)
                    begin
                        req_reg   <= '{1'b1, OP_MUL, UNIT_AW'(n_c), UNIT_BW'(n_c)};
                        state_reg <= S_N2;
                    end
                end
                S_N2:
                begin
                    if (u_done)
                    begin
                        n2_reg    <= u_res[32:16];
                        req_reg   <= '{1'b1, OP_MUL, UNIT_AW'(a_c), UNIT_BW'(bdiff_c)};
                        state_reg <= S_F;
                    end
                end
                S_F:
                begin
                    if (u_done)
                    begin
                        req_reg   <= '{1'b1, OP_MUL, UNIT_AW'(a_c), UNIT_BW'(f_c)};
                        state_reg <= S_R;
                    end
                end
                S_R:
                begin
                    if (u_done)
                    begin
                        r_reg     <= u_res[38:16];
                        req_reg   <= '{1'b1, OP_MUL, UNIT_AW'(n2_reg), UNIT_BW'(mb_reg)};
                        state_reg <= S_P1;
                    end
                end
                S_P1:
                begin
                    if (u_done)
                    begin
                        req_reg   <= '{1'b1, OP_MUL, u_res, UNIT_BW'(r_reg)};
                        state_reg <= S_P2;
                    end
                end
                S_P2:
                begin
                    if (u_done)
                    begin
                        blur_reg  <= (p_c > 24'd65535) ? 16'hFFFF : p_c[15:0];
                        state_reg <= S_OUT;
                    end
                end
                S_OUT:
                begin
                    if (!ov_reg || result.ready)
                    begin
                        ov_reg         <= 1'b1;
                        vx_out_reg     <= vx_reg;
                        vy_out_reg     <= vy_reg;
                        blur_out_reg   <= blur_reg;
                        primed_out_reg <= primed_reg;
                        state_reg      <= S_IDLE;
                    end
                    else if (ov_reg && result.ready)
                    begin
                        ov_reg <= 1'b0;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    assign result.valid      = ov_reg;
    assign result.velocity_x = signed'(vx_out_reg);
    assign result.velocity_y = signed'(vy_out_reg);
    assign result.blur_px    = blur_out_reg;
    assign result.primed     = primed_out_reg;

endmodule

FILE: rtl/core/cmbe_checker.sv
// Port-level checker for the estimator, bound to the top level.
// Depends on camera_motion_blur_estimator_unit_assert.svh.
`include "camera_motion_blur_estimator_unit_assert.svh"

module cmbe_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        in_valid,
    input logic        in_ready,
    input logic        out_valid,
    input logic        out_ready,
    input logic [39:0] velocity_x,
    input logic [39:0] velocity_y,
    input logic [15:0] blur_px,
    input logic        primed
);

    `CMBE_ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && !out_ready, out_valid && $stable(blur_px))
    `CMBE_ASSERT_IMPLY(a_primed_zero, clk, rst_n, out_valid && primed, velocity_x == 40'd0 && velocity_y == 40'd0 && blur_px == 16'd0)
    `CMBE_ASSERT_NEXT(a_busy_after_in, clk, rst_n, in_valid && in_ready, !in_ready)

endmodule

bind camera_motion_blur_estimator_unit cmbe_checker u_cmbe_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (frame.valid),
    .in_ready   (frame.ready),
    .out_valid  (result.valid),
    .out_ready  (result.ready),
    .velocity_x (result.velocity_x),
    .velocity_y (result.velocity_y),
    .blur_px    (result.blur_px),
    .primed     (result.primed)
);
